/* src/fwm_pkg.sv */
// Shared types, opcodes and default sizes for the mutex with an ordered wait queue.
package fwm_pkg;

    // Fixed widths of the item fields.
    localparam int OPCODE_W = 2;
    localparam int TID_W    = 16;

    // Defaults for the top-level parameters.
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 16;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CANCEL  = 2'd3;

    // Request item.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [TID_W-1:0]    thread_id;
    } t_fwm_in;

    // Result item.
    typedef struct packed {
        logic             granted;
        logic             waiting;
        logic             wake_valid;
        logic [TID_W-1:0] wake_thread;
        logic             status;
    } t_fwm_out;

    // Controls from the top level to the sequencer.
    typedef struct packed {
        logic start;
        logic out_free;
    } t_fwm_ctl;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_fwm_stat;

endpackage

/* src/fwm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module fwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fwm_seq.sv */
// Sequencer and queue datapath: lock flag, wait count, scan and compaction of the queue RAM.
module fwm_seq #(
    parameter int QUEUE_DEPTH    = fwm_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = fwm_pkg::THREAD_ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fwm_pkg::t_fwm_ctl i_ctl,
    input  fwm_pkg::t_fwm_in  i_item,
    output fwm_pkg::t_fwm_stat o_stat,
    output fwm_pkg::t_fwm_out o_result
);
    import fwm_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW = THREAD_ID_BITS;
    localparam int KW  = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_REL_RD   = 3'd1;
    localparam logic [2:0] ST_REL_CAP  = 3'd2;
    localparam logic [2:0] ST_SCAN_RD  = 3'd3;
    localparam logic [2:0] ST_SCAN_CMP = 3'd4;
    localparam logic [2:0] ST_SH_RD    = 3'd5;
    localparam logic [2:0] ST_SH_WR    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]          r_state, n_state;
    logic                r_locked, n_locked;
    logic [CW-1:0]       r_count, n_count;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [IDW-1:0]      r_id, n_id;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_found, n_found;
    t_fwm_out            r_res, n_res;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [IDW-1:0] ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [IDW-1:0] ram_rdata;

    logic [IDW-1:0] id_in;
    logic [CW-1:0]  ptr_inc;
    logic           match;
    logic           last;
    logic           found_now;
    logic [CW-1:0]  pos_now;

    // Wait queue storage.
    fwm_ram #(
        .WIDTH(IDW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Shared pointer increment and id compare.
    assign id_in     = IDW'(i_item.thread_id[KW-1:0]);
    assign ptr_inc   = r_ptr + CW'(1);
    assign match     = (ram_rdata == r_id);
    assign last      = (ptr_inc == r_count);
    assign found_now = r_found | match;
    assign pos_now   = r_found ? r_pos : r_ptr;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_locked  = r_locked;
        n_count   = r_count;
        n_op      = r_op;
        n_id      = r_id;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_found   = r_found;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_id;
        ram_raddr = r_ptr[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_item.opcode;
                    n_id    = id_in;
                    n_ptr   = '0;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_res   = '0;
                    case (i_item.opcode)
                        OP_ACQUIRE: begin
                            if (!r_locked) begin
                                n_locked      = 1'b1;
                                n_res.granted = 1'b1;
                            end else if (r_count < CW'(QUEUE_DEPTH)) begin
                                ram_we        = 1'b1;
                                ram_wdata     = id_in;
                                n_count       = r_count + CW'(1);
                                n_res.waiting = 1'b1;
                            end else begin
                                n_res.status = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        OP_RELEASE: begin
                            if (r_count == '0) begin
                                n_locked = 1'b0;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_REL_RD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res.granted = 1'b1;
                                n_state       = ST_DONE;
                            end else begin
                                n_state = ST_SCAN_RD;
                            end
                        end
                    endcase
                end
            end

            // Read the head waiter, then remove it by compaction.
            ST_REL_RD: begin
                ram_raddr = '0;
                n_state   = ST_REL_CAP;
            end
            ST_REL_CAP: begin
                n_res.wake_valid  = 1'b1;
                n_res.wake_thread = TID_W'(ram_rdata[KW-1:0]);
                n_ptr             = '0;
                n_state           = ST_SH_RD;
            end

            // Scan the queue oldest first, one entry per read and compare.
            ST_SCAN_RD: begin
                ram_raddr = r_ptr[AW-1:0];
                n_state   = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (r_op == OP_CHECK) begin
                    if (match) begin
                        n_res.waiting = 1'b1;
                        n_state       = ST_DONE;
                    end else if (last) begin
                        n_res.granted = 1'b1;
                        n_state       = ST_DONE;
                    end else begin
                        n_ptr   = ptr_inc;
                        n_state = ST_SCAN_RD;
                    end
                end else begin
                    // A second copy means the thread stays queued after removal.
                    if (r_found && match) begin
                        n_res.waiting = 1'b1;
                        n_ptr         = r_pos;
                        n_state       = ST_SH_RD;
                    end else if (last) begin
                        if (found_now) begin
                            n_ptr   = pos_now;
                            n_state = ST_SH_RD;
                        end else begin
                            n_res.granted = 1'b1;
                            n_state       = ST_DONE;
                        end
                    end else begin
                        n_found = found_now;
                        n_pos   = pos_now;
                        n_ptr   = ptr_inc;
                        n_state = ST_SCAN_RD;
                    end
                end
            end

            // Close the gap at r_ptr: move each later entry down by one.
            ST_SH_RD: begin
                if (ptr_inc == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end else begin
                    ram_raddr = ptr_inc[AW-1:0];
                    n_state   = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = ram_rdata;
                n_ptr     = ptr_inc;
                n_state   = ST_SH_RD;
            end

            // Hold the result until the output register can take it.
            ST_DONE: begin
                if (i_ctl.out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_locked <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_locked <= n_locked;
            r_count  <= n_count;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_id    <= n_id;
        r_ptr   <= n_ptr;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_res   <= n_res;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_result    = r_res;

endmodule

/* src/fifo_waiter_mutex.sv */
// One item at a time: release, check and cancel may walk the queue through the RAM's single
// read port, scanning or compacting entry by entry; ready returns once the result is stored.
// Reset (synchronous, active low) frees the lock and empties the queue; queue contents are
// left as they are and only entries below the wait count are ever read.
module fifo_waiter_mutex #(
    parameter int QUEUE_DEPTH    = fwm_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = fwm_pkg::THREAD_ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fwm_pkg::t_fwm_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fwm_pkg::t_fwm_out o_out_data
);
    import fwm_pkg::*;

    t_fwm_ctl  ctl;
    t_fwm_stat stat;
    t_fwm_out  result;
    logic      out_free;
    logic      r_out_valid;
    t_fwm_out  r_out_data;

    // Handshake glue around the sequencer.
    assign out_free     = !r_out_valid || i_out_ready;
    assign ctl.start    = i_in_valid && stat.idle;
    assign ctl.out_free = out_free;
    assign o_in_ready   = stat.idle;

    fwm_seq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_item  (i_in_data),
        .o_stat  (stat),
        .o_result(result)
    );

    // Output register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && out_free) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/fwm_checker.sv */
// Port-level assertions for the mutex block and the bind that attaches them.
module fwm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input fwm_pkg::t_fwm_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input fwm_pkg::t_fwm_out o_out_data
);
    import fwm_pkg::*;

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted back to back");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A wakeup or a rejection reports neither a grant nor a wait.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.wake_valid || o_out_data.status))
            |-> (!o_out_data.granted && !o_out_data.waiting))
        else $error("wakeup or rejection mixed with grant or wait");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fifo_waiter_mutex fwm_checker u_fwm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

/* tb/sv/fifo_waiter_mutex_tb.sv */
// Self-checking testbench for the mutex with an ordered queue of waiting threads.
`timescale 1ns / 1ps

module fifo_waiter_mutex_tb;
    import fwm_pkg::*;

    localparam int ITEMS_PER_PHASE = 630;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 100;

    // Fixed results that can be read straight off the spec.
    localparam t_fwm_out RES_NONE  = '0;
    localparam t_fwm_out RES_GRANT = t_fwm_out'({1'b1, 1'b0, 1'b0, 16'h0, 1'b0});
    localparam t_fwm_out RES_WAIT  = t_fwm_out'({1'b0, 1'b1, 1'b0, 16'h0, 1'b0});
    localparam t_fwm_out RES_FULL  = t_fwm_out'({1'b0, 1'b0, 1'b0, 16'h0, 1'b1});

    // Operation mixes for the random bursts.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // One row of the directed plan; thread_id advances by one per repeat.
    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [TID_W-1:0]    tid;
        int                  reps;
        bit                  typed;
        t_fwm_out            res;
    } t_plan_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_fwm_in  i_in_data   = '0;
    logic     i_out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_fwm_out o_out_data;

    // Predictor state: lock owner flag and the ordered waiter list.
    bit               mutex_held = 1'b0;
    logic [TID_W-1:0] waiters[$];

    // Results owed by the block, oldest first.
    t_fwm_out         lock_replies_q[$];
    t_fwm_out         due_reply;

    int               err_count     = 0;
    int               tx_idle_pct   = 0;
    int               rx_idle_pct   = 40;
    bit               rx_hold_req   = 1'b0;
    bit               rx_hold_taken = 1'b0;
    int               rx_hold_left  = 0;
    logic [TID_W-1:0] tid_pool[6];

    t_plan_row plan[] = '{
        '{OP_RELEASE, 16'h0000,  1, 1'b1, RES_NONE},   // release while free
        '{OP_CHECK,   16'hFFFF,  1, 1'b1, RES_GRANT},  // check on empty queue
        '{OP_CANCEL,  16'h0000,  1, 1'b1, RES_GRANT},  // cancel on empty queue
        '{OP_ACQUIRE, 16'h0000,  1, 1'b1, RES_GRANT},  // lock is free
        '{OP_ACQUIRE, 16'hFFFF,  1, 1'b1, RES_WAIT},   // lock is held
        '{OP_ACQUIRE, 16'h0000,  1, 1'b0, RES_NONE},   // owner queues itself
        '{OP_ACQUIRE, 16'hFFFF,  1, 1'b0, RES_NONE},   // duplicate waiter
        '{OP_CHECK,   16'hFFFF,  1, 1'b0, RES_NONE},
        '{OP_CHECK,   16'h0000,  1, 1'b0, RES_NONE},
        '{OP_CHECK,   16'h1234,  1, 1'b0, RES_NONE},   // absent while held by another
        '{OP_CANCEL,  16'hFFFF,  1, 1'b0, RES_NONE},   // a copy remains
        '{OP_CANCEL,  16'hFFFF,  1, 1'b0, RES_NONE},   // last copy removed
        '{OP_RELEASE, 16'h0000,  1, 1'b0, RES_NONE},   // hand over to head
        '{OP_ACQUIRE, 16'hA5A0, 16, 1'b0, RES_NONE},   // fill the queue
        '{OP_ACQUIRE, 16'h5A5A,  1, 1'b1, RES_FULL},   // queue full
        '{OP_CHECK,   16'hA5A7,  1, 1'b0, RES_NONE},
        '{OP_CANCEL,  16'hA5A7,  1, 1'b0, RES_NONE},   // remove from the middle
        '{OP_CHECK,   16'hA5AF,  1, 1'b0, RES_NONE},
        '{OP_ACQUIRE, 16'h5A5A,  1, 1'b0, RES_NONE},   // slot freed by cancel
        '{OP_RELEASE, 16'h0000, 17, 1'b0, RES_NONE},   // drain, then free the lock
        '{OP_RELEASE, 16'h0000,  1, 1'b1, RES_NONE},
        '{OP_CANCEL,  16'h5A5A,  1, 1'b1, RES_GRANT}
    };

    fifo_waiter_mutex u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Position of the oldest queued copy of a thread, or -1.
    function automatic int oldest_waiter(input logic [TID_W-1:0] tid);
        for (int i = 0; i < waiters.size(); i++) begin
            if (waiters[i] == tid) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the predicted lock state and returns its result.
    function automatic t_fwm_out apply_lock_op(input t_fwm_in req);
        t_fwm_out res;
        int       pos;
        res = '0;
        case (req.opcode)
            OP_ACQUIRE: begin
                if (!mutex_held) begin
                    mutex_held = 1'b1;
                    res.granted = 1'b1;
                end else if (waiters.size() < QUEUE_DEPTH_DEF) begin
                    waiters.push_back(req.thread_id);
                    res.waiting = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (waiters.size() == 0) begin
                    mutex_held = 1'b0;
                end else begin
                    res.wake_valid  = 1'b1;
                    res.wake_thread = waiters.pop_front();
                end
            end
            default: begin
                pos = oldest_waiter(req.thread_id);
                if (pos < 0) begin
                    res.granted = 1'b1;
                end else if (req.opcode == OP_CHECK) begin
                    res.waiting = 1'b1;
                end else begin
                    waiters.delete(pos);
                    res.waiting = (oldest_waiter(req.thread_id) >= 0);
                end
            end
        endcase
        return res;
    endfunction

    // Random request: ids mostly from a small pool so that checks and cancels hit.
    function automatic t_fwm_in pick_request(input t_mix mix);
        t_fwm_in req;
        int      roll;
        int      acq_cut;
        int      rel_cut;
        int      chk_cut;
        case (mix)
            MIX_FILL:  begin acq_cut = 60; rel_cut = 70; chk_cut = 85; end
            MIX_DRAIN: begin acq_cut = 15; rel_cut = 60; chk_cut = 80; end
            default:   begin acq_cut = 35; rel_cut = 60; chk_cut = 80; end
        endcase
        roll = $urandom_range(99);
        if (roll < acq_cut) begin
            req.opcode = OP_ACQUIRE;
        end else if (roll < rel_cut) begin
            req.opcode = OP_RELEASE;
        end else if (roll < chk_cut) begin
            req.opcode = OP_CHECK;
        end else begin
            req.opcode = OP_CANCEL;
        end
        if ($urandom_range(9) < 8) begin
            req.thread_id = tid_pool[$urandom_range(5)];
        end else begin
            req.thread_id = TID_W'($urandom_range(16'hFFFF));
        end
        return req;
    endfunction

    // Offers one item, waits for it to be taken and records the owed result.
    task automatic push_item(input t_fwm_in req, input bit typed, input t_fwm_out fixed);
        t_fwm_out predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_lock_op(req);
        lock_replies_q.push_back(typed ? fixed : predicted);
        @(negedge i_clk);
    endtask

    // Stops offering until every owed result has come back.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (lock_replies_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            err_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Receiver: random back-pressure, or a long hold when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_taken) begin
            rx_hold_taken = 1'b1;
            rx_hold_left  = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each taken result with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lock_replies_q.size() == 0) begin
                err_count++;
                $error("result item arrived with none outstanding");
            end else begin
                due_reply = lock_replies_q.pop_front();
                cmp_field("granted", TID_W'(due_reply.granted),
                          TID_W'(o_out_data.granted));
                cmp_field("waiting", TID_W'(due_reply.waiting),
                          TID_W'(o_out_data.waiting));
                cmp_field("wake_valid", TID_W'(due_reply.wake_valid),
                          TID_W'(o_out_data.wake_valid));
                cmp_field("wake_thread", due_reply.wake_thread, o_out_data.wake_thread);
                cmp_field("status", TID_W'(due_reply.status),
                          TID_W'(o_out_data.status));
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    initial begin
        int stuck;
        stuck = 0;
        wait (i_rst_n);
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus: directed plan, then three random phases with different idling.
    initial begin
        t_fwm_in req;
        t_mix    mix;
        tid_pool[0] = 16'h0000;
        tid_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++) begin
            tid_pool[i] = TID_W'($urandom_range(16'hFFFF));
        end
        mix = MIX_EVEN;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                req.opcode    = plan[r].op;
                req.thread_id = plan[r].tid + TID_W'(k);
                push_item(req, plan[r].typed, plan[r].res);
            end
        end
        drain_replies();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 12; rx_idle_pct = 88; end
                1:       begin tx_idle_pct = 88; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // In the last phase the receiver stalls for a long stretch first.
            if (ph == 2) begin
                @(posedge i_clk);
                rx_hold_req = 1'b1;
                @(negedge i_clk);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    mix = t_mix'($urandom_range(2));
                end
                push_item(pick_request(mix), 1'b0, RES_NONE);
            end
            drain_replies();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
